// File: rtl/vfc_pkg.sv
// Package for the voxel fractal classifier: register indexes, mode codes,
// reset values, the flag bundle carried down the pipeline and digit-count helpers.
// No dependencies.
`default_nettype none

package vfc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int RADIUS_W       = 16;
    localparam int MODE_W         = 2;
    localparam int CFG_INDEX_W    = 8;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_GEN_MODE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS   = CFG_INDEX_W'(1);

    // generation modes
    localparam logic [MODE_W-1:0] MODE_FLAT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MENGER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SKY    = 2'd2;

    localparam logic [MODE_W-1:0]   GEN_MODE_RESET = MODE_MENGER;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 16'd16;

    localparam logic KIND_AIR   = 1'b0;
    localparam logic KIND_STONE = 1'b1;

    typedef struct packed {
        logic plat;   // inside the platform sphere
        logic zneg;   // z below zero
        logic zzero;  // z equal to zero
        logic grid;   // all three coordinates multiples of four
        logic air;    // some base-3 level had two or more digits equal to one
    } vfc_flags_t;

    // 3 to the power k, for elaboration only
    function automatic longint pow3(input int k);
        longint p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 3;
        end
        return p;
    endfunction

    // base-3 digits needed to cover a magnitude up to 2^(bits-1)
    function automatic int num_digits(input int bits);
        int     n;
        longint p;
        n = 1;
        p = 3;
        while (p <= (longint'(1) << (bits - 1))) begin
            p = p * 3;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/vfc_coord_if.sv
// Coordinate channel: valid/ready plus one signed voxel coordinate.
// Depends on vfc_pkg.
`default_nettype none

interface vfc_coord_if #(
    parameter int COORD_BITS = vfc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

// File: rtl/vfc_kind_if.sv
// Result channel: valid/ready plus the voxel class.
// No dependencies.
`default_nettype none

interface vfc_kind_if;
    logic valid;
    logic ready;
    logic block_kind;

    modport source (output valid, block_kind, input ready);
    modport sink   (input valid, block_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/vfc_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on vfc_pkg.
`default_nettype none

interface vfc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vfc_pkg::CFG_INDEX_W-1:0]  index;
    logic [vfc_pkg::RADIUS_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/vfc_front.sv
// Front stages: magnitudes and sign flags, squares, then the platform compare.
// Three registered stages with per-stage handshake. Depends on vfc_pkg.
`default_nettype none

module vfc_front #(
    parameter int COORD_BITS = vfc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic signed [COORD_BITS-1:0]        pos_x,
    input  wire logic signed [COORD_BITS-1:0]        pos_y,
    input  wire logic signed [COORD_BITS-1:0]        pos_z,
    input  wire logic [vfc_pkg::RADIUS_W-1:0]        radius,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic [2:0][COORD_BITS-1:0]          out_mag,
    output      vfc_pkg::vfc_flags_t                 out_flags
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int R2_W  = 2 * vfc_pkg::RADIUS_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                       s1_ready, s2_ready, s3_ready;
    logic [2:0][COORD_BITS-1:0] s1_mag_reg, s2_mag_reg, s3_mag_reg;
    vfc_pkg::vfc_flags_t        s1_flags_reg, s2_flags_reg, s3_flags_reg;
    logic [2:0][SQ_W-1:0]       s2_sq_reg;
    logic [R2_W-1:0]            s2_r2_reg;
    logic [2:0][COORD_BITS-1:0] mag_next;
    vfc_pkg::vfc_flags_t        flags_next;
    vfc_pkg::vfc_flags_t        s3_flags_next;
    logic [SUM_W-1:0]           sum;
    logic                       plat;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // magnitude of two's complement: the most negative value maps to 2^(n-1)
    always_comb
    begin
        mag_next[0] = pos_x[COORD_BITS-1] ? (~pos_x + 1'b1) : pos_x;
        mag_next[1] = pos_y[COORD_BITS-1] ? (~pos_y + 1'b1) : pos_y;
        mag_next[2] = pos_z[COORD_BITS-1] ? (~pos_z + 1'b1) : pos_z;
        flags_next.plat  = 1'b0;
        flags_next.zneg  = pos_z[COORD_BITS-1];
        flags_next.zzero = (pos_z == '0);
        flags_next.grid  = (pos_x[1:0] == 2'b00) && (pos_y[1:0] == 2'b00)
                           && (pos_z[1:0] == 2'b00);
        flags_next.air   = 1'b0;
    end

    assign sum  = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
    assign plat = (CMP_W'(sum) <= CMP_W'(s2_r2_reg));

    always_comb
    begin
        s3_flags_next      = s2_flags_reg;
        s3_flags_next.plat = plat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_mag_reg   <= mag_next;
            s1_flags_reg <= flags_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_mag_reg   <= s1_mag_reg;
            s2_flags_reg <= s1_flags_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_sq_reg[i] <= SQ_W'(s1_mag_reg[i]) * SQ_W'(s1_mag_reg[i]);
            end
            s2_r2_reg <= R2_W'(radius) * R2_W'(radius);
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_mag_reg   <= s2_mag_reg;
            s3_flags_reg <= s3_flags_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_mag   = s3_mag_reg;
    assign out_flags = s3_flags_reg;

endmodule

`default_nettype wire

// File: rtl/vfc_digit_cell.sv
// One base-3 level of the sponge test: strip digit LEVEL from each magnitude
// and mark air when two or more digits equal one. Depends on vfc_pkg.
`default_nettype none

module vfc_digit_cell #(
    parameter int COORD_BITS = vfc_pkg::COORD_BITS_DEF,
    parameter int LEVEL      = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_ready,
    input  wire logic [2:0][COORD_BITS-1:0] in_mag,
    input  wire vfc_pkg::vfc_flags_t        in_flags,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic [2:0][COORD_BITS-1:0] out_mag,
    output      vfc_pkg::vfc_flags_t        out_flags
);

    localparam int EXT_W = COORD_BITS + 1;
    localparam logic [EXT_W-1:0] P1 = EXT_W'(vfc_pkg::pow3(LEVEL));
    localparam logic [EXT_W-1:0] P2 = EXT_W'(2 * vfc_pkg::pow3(LEVEL));

    logic                       valid_reg;
    logic [2:0][COORD_BITS-1:0] mag_reg;
    vfc_pkg::vfc_flags_t        flags_reg;
    logic [2:0][COORD_BITS-1:0] mag_next;
    logic [2:0]                 one;
    vfc_pkg::vfc_flags_t        flags_next;

    // incoming magnitude stays below 3^(LEVEL+1), so two compares find the digit
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            one[i]      = 1'b0;
            mag_next[i] = in_mag[i];
            if (EXT_W'(in_mag[i]) >= P2)
            begin
                mag_next[i] = COORD_BITS'(EXT_W'(in_mag[i]) - P2);
            end
            else if (EXT_W'(in_mag[i]) >= P1)
            begin
                one[i]      = 1'b1;
                mag_next[i] = COORD_BITS'(EXT_W'(in_mag[i]) - P1);
            end
        end
        flags_next     = in_flags;
        flags_next.air = in_flags.air || (one[0] && one[1]) || (one[0] && one[2])
                         || (one[1] && one[2]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mag_reg   <= mag_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;
    assign out_flags = flags_reg;

`ifndef SYNTHESIS
    // after this level every remainder is below 3^LEVEL
    a_rem_below_level: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (EXT_W'(mag_reg[0]) < P1) && (EXT_W'(mag_reg[1]) < P1)
                      && (EXT_W'(mag_reg[2]) < P1))
        else $error("digit cell remainder not below its level");
    // an air mark, once set, survives the cell
    a_air_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_flags.air |=> flags_reg.air)
        else $error("air mark lost in digit cell");
    // a waiting transfer holds its contents until taken
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(mag_reg) && $stable(flags_reg))
        else $error("digit cell output changed while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/voxel_fractal_classifier.sv
// Top level of the voxel fractal classifier: configuration registers, front
// stages, the chain of base-3 digit cells and the result register.
// Depends on vfc_pkg, the three channel interfaces, vfc_front, vfc_digit_cell.
//
//  channel | dir | payload                           | transfer when
//  --------+-----+-----------------------------------+--------------------------
//  coord   | in  | pos_x, pos_y, pos_z (signed)      | coord.valid && coord.ready
//  result  | out | block_kind (0 air, 1 stone)       | result.valid && result.ready
//  cfg     | in  | index, data (0 gen_mode, 1 radius)| cfg.valid && cfg.ready
//
// A voxel passes three front stages, N digit cells, then the result register;
// N is the number of base-3 digits of a magnitude, 15 at 24-bit coordinates.
// One voxel is taken per cycle while the result is not stalled; every stage
// is a register with its own ready. A stalled result holds the last stage
// and backs up only as far as the bubbles allow. Reset clears the stage valids
// and loads gen_mode = menger sponge and radius = 16; cfg is always ready.
`default_nettype none

module voxel_fractal_classifier #(
    parameter int COORD_BITS = vfc_pkg::COORD_BITS_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    vfc_coord_if.sink    coord,
    vfc_kind_if.source   result,
    vfc_cfg_if.sink      cfg
);

    localparam int N = vfc_pkg::num_digits(COORD_BITS);

    logic [vfc_pkg::MODE_W-1:0]   gen_mode_reg;
    logic [vfc_pkg::RADIUS_W-1:0] radius_reg;

    logic [N:0]                 chain_valid;
    logic [N:0]                 chain_ready;
    logic [2:0][COORD_BITS-1:0] chain_mag   [N+1];
    vfc_pkg::vfc_flags_t        chain_flags [N+1];

    logic                last_valid;
    logic                last_ready;
    vfc_pkg::vfc_flags_t last_flags;
    logic                out_valid_reg;
    logic                kind_reg;
    logic                kind_next;

    // configuration: writes land at once, values masked to register width
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_mode_reg <= vfc_pkg::GEN_MODE_RESET;
            radius_reg   <= vfc_pkg::RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == vfc_pkg::REG_GEN_MODE)
            begin
                gen_mode_reg <= cfg.data[vfc_pkg::MODE_W-1:0];
            end
            else if (cfg.index == vfc_pkg::REG_RADIUS)
            begin
                radius_reg <= cfg.data;
            end
        end
    end

    // front: magnitudes, squares, platform compare
    vfc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coord.valid),
        .in_ready  (coord.ready),
        .pos_x     (coord.pos_x),
        .pos_y     (coord.pos_y),
        .pos_z     (coord.pos_z),
        .radius    (radius_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_mag   (chain_mag[0]),
        .out_flags (chain_flags[0])
    );

    // digit chain: most significant level first, one level per cell
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        vfc_digit_cell #(
            .COORD_BITS (COORD_BITS),
            .LEVEL      (N - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_mag    (chain_mag[g]),
            .in_flags  (chain_flags[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_mag   (chain_mag[g+1]),
            .out_flags (chain_flags[g+1])
        );
    end

    assign last_valid     = chain_valid[N];
    assign last_flags     = chain_flags[N];
    assign last_ready     = !out_valid_reg || result.ready;
    assign chain_ready[N] = last_ready;

    // final decision: platform first, then the mode; the remainders of the
    // chain are all zero by now and go unused
    always_comb
    begin
        kind_next = vfc_pkg::KIND_AIR;
        priority if (last_flags.plat)
        begin
            kind_next = last_flags.zneg ? vfc_pkg::KIND_STONE : vfc_pkg::KIND_AIR;
        end
        else
        begin
            unique case (gen_mode_reg)
                vfc_pkg::MODE_FLAT:
                    kind_next = (!last_flags.zneg && !last_flags.zzero)
                                ? vfc_pkg::KIND_AIR : vfc_pkg::KIND_STONE;
                vfc_pkg::MODE_MENGER:
                    kind_next = last_flags.air ? vfc_pkg::KIND_AIR : vfc_pkg::KIND_STONE;
                vfc_pkg::MODE_SKY:
                    kind_next = last_flags.grid ? vfc_pkg::KIND_STONE : vfc_pkg::KIND_AIR;
                default:
                    kind_next = vfc_pkg::KIND_AIR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (last_ready)
        begin
            out_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && last_ready)
        begin
            kind_reg <= kind_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.block_kind = kind_reg;

`ifndef SYNTHESIS
    // inside the platform the answer is the sign of z alone
    a_platform_kind: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid && last_ready && last_flags.plat
        |=> result.block_kind == $past(last_flags.zneg))
        else $error("platform voxel classified against sign of z");
    // a result appears only from a transfer out of the last cell
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_valid))
        else $error("result valid without a last-cell transfer");
    // sky grid off the grid and outside the platform is always air
    a_sky_air: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid && last_ready && !last_flags.plat && !last_flags.grid
        && gen_mode_reg == vfc_pkg::MODE_SKY |=> result.block_kind == vfc_pkg::KIND_AIR)
        else $error("sky grid voxel off the grid not air");
`endif

endmodule

`default_nettype wire
